FILE: design/rlkd_pkg.sv
// Shared constants, register indexes and event code tables for the keypad decoder.
package rlkd_pkg;

  localparam int unsigned SampleBitsDef = 10;
  localparam int unsigned CountBitsDef  = 8;

  localparam int unsigned NumKeys  = 6;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned HalfW    = 8;
  localparam int unsigned LimitW   = 8;
  localparam int unsigned EventW   = 4;

  localparam logic [HalfW-1:0]  HalfwidthRst = HalfW'(10);
  localparam logic [LimitW-1:0] LimitRst     = LimitW'(50);

  typedef enum logic [RegIdxW-1:0] {
    REG_UP        = 3'd0,
    REG_DOWN      = 3'd1,
    REG_POWER     = 3'd2,
    REG_ADVANCE   = 3'd3,
    REG_FASTER    = 3'd4,
    REG_SLOWER    = 3'd5,
    REG_HALFWIDTH = 3'd6,
    REG_LIMIT     = 3'd7
  } cfg_reg_e;

  localparam logic [EventW-1:0] EV_NONE        = 4'd0;
  localparam logic [EventW-1:0] EV_UP          = 4'd1;
  localparam logic [EventW-1:0] EV_UP_LONG     = 4'd2;
  localparam logic [EventW-1:0] EV_DOWN        = 4'd3;
  localparam logic [EventW-1:0] EV_DOWN_LONG   = 4'd4;
  localparam logic [EventW-1:0] EV_POWER       = 4'd5;
  localparam logic [EventW-1:0] EV_POWER_LONG  = 4'd6;
  localparam logic [EventW-1:0] EV_NEXT        = 4'd7;
  localparam logic [EventW-1:0] EV_FASTER      = 4'd8;
  localparam logic [EventW-1:0] EV_FASTER_LONG = 4'd9;
  localparam logic [EventW-1:0] EV_SLOWER      = 4'd10;
  localparam logic [EventW-1:0] EV_SLOWER_LONG = 4'd11;

  typedef logic [EventW-1:0] event_code_t;
  typedef event_code_t code_tab_t [NumKeys];

  localparam code_tab_t ShortCode = '{
    EV_UP, EV_DOWN, EV_POWER, EV_NEXT, EV_FASTER, EV_SLOWER
  };
  localparam code_tab_t LongCode = '{
    EV_UP_LONG, EV_DOWN_LONG, EV_POWER_LONG, EV_NEXT, EV_FASTER_LONG, EV_SLOWER_LONG
  };

endpackage

FILE: design/resistor_ladder_key_decoder.sv
// Resistor-ladder keypad decoder: window compares, press counting and release events.
//
// Usage:
//   Slave stream (s_axis_*) carries one converter sample per word. Master stream
//   (m_axis_*) returns exactly one word per sample: an event code (zero when no
//   key was released) and the LED level after that sample.
//   Configuration is a plain write port: cfg_we_i, cfg_addr_i, cfg_wdata_i; write
//   only while no sample is in flight.
//   Path: an accepted sample is registered in the input register, decoded against
//   the six key windows and registered again in the result register that drives
//   the master side; a master-side stall can hold it in the input register.
//   Throughput: one sample per cycle unless the master stalls; the window compares
//   and the chained counter update sit between the input and result registers.
//   Reset: key state, press counter and LED clear, levels go to zero, half-width
//   to 10 and long-press limit to 50; both stream registers empty.
//   Stall: while m_axis_tready_i is low the result is held; one more sample is
//   taken into the input register, then s_axis_tready_o drops.
module resistor_ladder_key_decoder #(
  parameter int unsigned SAMPLE_BITS = rlkd_pkg::SampleBitsDef,
  parameter int unsigned COUNT_BITS  = rlkd_pkg::CountBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [SAMPLE_BITS-1:0] sample, rest zero
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // [3:0] event_code, [4] led_dim, [7:5] zero
  output logic [7:0]                           m_axis_tdata_o,
  input  logic                                 cfg_we_i,
  input  logic [rlkd_pkg::RegIdxW-1:0]         cfg_addr_i,
  input  logic [SAMPLE_BITS-1:0]               cfg_wdata_i
);
  import rlkd_pkg::*;

  localparam int unsigned SumW = SAMPLE_BITS + 1;
  localparam int unsigned CmpW = (COUNT_BITS > LimitW) ? COUNT_BITS : LimitW;
  localparam logic [COUNT_BITS-1:0] CntMax = {COUNT_BITS{1'b1}};

  logic [SAMPLE_BITS-1:0] level_q [NumKeys];
  logic [HalfW-1:0]       half_q;
  logic [LimitW-1:0]      limit_q;

  logic                   in_vld_q;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic                   out_vld_q;
  event_code_t            code_q, code_d;
  logic                   led_out_q;

  logic [NumKeys-1:0]     held_q, held_d;
  logic [COUNT_BITS-1:0]  cnt_q, cnt_d;
  logic                   led_q, led_d;
  logic [NumKeys-1:0]     win;
  logic                   advance;

  assign advance         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {3'b000, led_out_q, code_q};

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumKeys; i++) level_q[i] <= '0;
      half_q  <= HalfwidthRst;
      limit_q <= LimitRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_UP, REG_DOWN, REG_POWER, REG_ADVANCE, REG_FASTER, REG_SLOWER: begin
          level_q[cfg_addr_i] <= cfg_wdata_i;
        end
        REG_HALFWIDTH: half_q  <= cfg_wdata_i[HalfW-1:0];
        REG_LIMIT:     limit_q <= cfg_wdata_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  // level - hw < s < level + hw, rearranged to stay unsigned
  always_comb begin
    for (int k = 0; k < NumKeys; k++) begin
      win[k] = ((SumW'(sample_q) + SumW'(half_q)) > SumW'(level_q[k])) &&
               ((SumW'(level_q[k]) + SumW'(half_q)) > SumW'(sample_q));
    end
  end

  always_comb begin
    logic done;
    held_d = held_q;
    cnt_d  = cnt_q;
    led_d  = led_q;
    code_d = EV_NONE;
    done   = 1'b0;
    for (int k = 0; k < NumKeys; k++) begin
      if (!done) begin
        if (win[k]) begin
          held_d[k] = 1'b1;
          if (cnt_d != CntMax) cnt_d = cnt_d + 1'b1;
          led_d = !(CmpW'(cnt_d) > CmpW'(limit_q));
        end else if (held_q[k]) begin
          held_d[k] = 1'b0;
          code_d    = (CmpW'(cnt_d) > CmpW'(limit_q)) ? LongCode[k] : ShortCode[k];
          led_d     = 1'b0;
          cnt_d     = '0;
          done      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      held_q    <= '0;
      cnt_q     <= '0;
      led_q     <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        held_q    <= held_d;
        cnt_q     <= cnt_d;
        led_q     <= led_d;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      sample_q <= s_axis_tdata_i[SAMPLE_BITS-1:0];
    end
    if (advance) begin
      code_q    <= code_d;
      led_out_q <= led_d;
    end
  end

endmodule
